[src/gsp_pkg.sv]
// gsp_pkg: shared types, character codes, field numbers and helper functions
// for the gga sentence parser; used by every file under src but gsp_ifs
// depends on nothing
`default_nettype none

package gsp_pkg;

  // fraction digits kept for latitude and longitude, and for altitude
  localparam int COORD_FRAC_DIGITS = 5;
  localparam int ALT_FRAC_DIGITS   = 2;

  // sentences held between the byte parser and the result pipeline
  localparam int QUEUE_DEPTH_DEF = 2;

  // ascii codes the parser reacts to
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_POINT    = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_FIX_GPS  = 8'h31;
  localparam logic [7:0] CH_FIX_DGPS = 8'h32;
  localparam logic [7:0] CH_FIX_EST  = 8'h36;

  // field numbers (comma count)
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_LAT    = 4'd2;
  localparam logic [3:0] FLD_NS     = 4'd3;
  localparam logic [3:0] FLD_LON    = 4'd4;
  localparam logic [3:0] FLD_EW     = 4'd5;
  localparam logic [3:0] FLD_FIX    = 4'd6;
  localparam logic [3:0] FLD_SATS   = 4'd7;
  localparam logic [3:0] FLD_ALT    = 4'd9;
  localparam logic [3:0] FLD_UNIT   = 4'd10;
  localparam logic [3:0] FLD_MAX    = 4'd15;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FIX    = 2'd1;
  localparam logic [1:0] ST_SHORT_LAT = 2'd2;

  // saturation limits
  localparam logic [19:0] TIME_MAX    = 20'd999999;
  localparam logic [19:0] SAT_MAX     = 20'd99;
  localparam logic [30:0] LAT_MAX     = 31'h3FFF_FFFF;
  localparam logic [30:0] LON_MAX     = 31'h7FFF_FFFF;
  localparam logic [30:0] ALT_MAX     = 31'h007F_FFFF;
  localparam logic [3:0]  LAT_MIN_LEN = 4'd6;

  // offset register reset value, +05:30
  localparam logic [11:0] UTC_OFFSET_RST = 12'd530;

  // reciprocals of 100 for division by multiply and shift
  localparam logic [20:0] TIME_RECIP  = 21'd1342178;  // ceil(2^27/100)
  localparam int          TIME_SHIFT  = 27;
  localparam logic [13:0] HUND_RECIP  = 14'd10486;    // ceil(2^20/100)
  localparam int          HUND_SHIFT  = 20;
  localparam logic [11:0] OFF_RECIP   = 12'd2622;     // ceil(2^18/100)
  localparam int          OFF_SHIFT   = 18;

  // one finished sentence, as it leaves the byte parser
  typedef struct packed {
    logic [19:0] time_acc;
    logic [29:0] lat_acc;
    logic        lat_short;
    logic [30:0] lon_acc;
    logic [7:0]  ns_letter;
    logic [7:0]  ew_letter;
    logic        fix_ok;
    logic [6:0]  sat_acc;
    logic [22:0] alt_mag;
    logic        alt_neg;
    logic [7:0]  unit_letter;
  } gsp_sent_t;

  // outcome of one character in a fixed-point field
  typedef struct packed {
    logic [30:0] acc;
    logic        seen;
    logic [2:0]  frac;
  } gsp_fix_t;

  // outcome of one character in an integer field
  typedef struct packed {
    logic [19:0] acc;
    logic        seen;
  } gsp_int_t;

  function automatic logic gsp_is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // powers of ten, capped at 10^9
  function automatic logic [29:0] gsp_pow10(input logic [3:0] n);
    logic [29:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

  // one character of a fixed-point field with scale fraction digits
  function automatic gsp_fix_t gsp_fixed_char(input logic [30:0] acc, input logic [7:0] c,
                                               input logic seen, input logic [2:0] frac,
                                               input logic [2:0] scale,
                                               input logic [30:0] cap);
    gsp_fix_t    r;
    logic [36:0] sum;
    logic [2:0]  fnew;
    r.acc  = acc;
    r.seen = seen;
    r.frac = frac;
    sum    = '0;
    fnew   = frac + 3'd1;
    if (c == CH_POINT) begin
      r.seen = 1'b1;
    end else if (gsp_is_digit(c)) begin
      if (!seen) begin
        sum = (37'(acc) << 3) + (37'(acc) << 1)
            + 37'(c[3:0]) * 37'(gsp_pow10({1'b0, scale}));
        r.acc = (sum > 37'(cap)) ? cap : sum[30:0];
      end else if (frac < scale) begin
        r.frac = fnew;
        sum = 37'(acc) + 37'(c[3:0]) * 37'(gsp_pow10({1'b0, scale - fnew}));
        r.acc = (sum > 37'(cap)) ? cap : sum[30:0];
      end
    end
    return r;
  endfunction

  // one character of an integer field that ends at its first non-digit
  function automatic gsp_int_t gsp_int_char(input logic [19:0] acc, input logic [7:0] c,
                                            input logic seen, input logic [19:0] cap);
    gsp_int_t    r;
    logic [23:0] sum;
    r.acc  = acc;
    r.seen = seen;
    sum    = '0;
    if (!seen) begin
      if (!gsp_is_digit(c)) begin
        r.seen = 1'b1;
      end else begin
        sum   = (24'(acc) << 3) + (24'(acc) << 1) + 24'(c[3:0]);
        r.acc = (sum > 24'(cap)) ? cap : sum[19:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/gsp_ifs.sv]
// gsp_ifs: valid/ready channel interfaces of the gga sentence parser
// (sentence bytes in, parsed results out, offset register writes)
// depends on nothing
`default_nettype none

interface gsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] sentence_byte;
  logic       sentence_end;
  modport source (output valid, sentence_byte, sentence_end, input ready);
  modport sink   (input valid, sentence_byte, sentence_end, output ready);
endinterface

interface gsp_result_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [6:0] hour;
  logic signed [7:0] minute;
  logic [6:0]        second;
  logic [29:0]       latitude;
  logic [7:0]        north_south;
  logic [30:0]       longitude;
  logic [7:0]        east_west;
  logic [6:0]        satellites;
  logic signed [23:0] altitude;
  logic [7:0]        altitude_unit;
  modport source (output valid, status, hour, minute, second, latitude, north_south,
                  longitude, east_west, satellites, altitude, altitude_unit,
                  input ready);
  modport sink   (input valid, status, hour, minute, second, latitude, north_south,
                  longitude, east_west, satellites, altitude, altitude_unit,
                  output ready);
endinterface

interface gsp_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] utc_offset_hhmm;
  modport source (output valid, utc_offset_hhmm, input ready);
  modport sink   (input valid, utc_offset_hhmm, output ready);
endinterface

`default_nettype wire

[src/gga_sentence_parser.sv]
// gga_sentence_parser: top level of the gga position sentence parser
// depends on gsp_pkg, gsp_ifs, gsp_front, gsp_queue and gsp_back
//
// usage
//   in_if  : one sentence character a beat, sentence_end marks the last one
//   out_if : one parsed result for every sentence, with status, local time,
//            coordinates, hemispheres, satellites and altitude
//   cfg_if : writes the signed hhmm utc offset; always ready, write it only
//            while no sentence is in flight
// throughput: one byte every cycle while the queue is not full; a sentence of
//   any length, even a single byte, yields its result with no bubble, so results
//   can also leave one a cycle while the receiver is ready
// path: the last byte's sentence enters the queue, then the hhmm split, hours
//   and seconds split, and offset and status stage registers hold it in turn
// stall: a stalled receiver holds the result register; up to QUEUE_DEPTH
//   further sentences wait in the queue, and in_if.ready drops only when it
//   is full
// reset: rst_n low clears the sentence state, the queue and the pipeline,
//   and sets the offset to +05:30
`default_nettype none

module gga_sentence_parser #(
  parameter int QUEUE_DEPTH = gsp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  gsp_byte_if.sink     in_if,
  gsp_result_if.source out_if,
  gsp_cfg_if.sink      cfg_if
);

  logic               q_push, q_full, q_pop, q_valid;
  gsp_pkg::gsp_sent_t q_wdata, q_rdata;

  // byte parser
  gsp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // sentence queue
  gsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_rdata)
  );

  // result pipeline
  gsp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_if  (cfg_if),
    .out_if  (out_if),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop)
  );

endmodule

`default_nettype wire

[src/gsp_front.sv]
// gsp_front: byte parser; counts fields, builds the values digit by digit and
// hands each finished sentence to the queue
// depends on gsp_pkg and gsp_ifs
`default_nettype none

module gsp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  gsp_byte_if.sink           in_if,
  input  wire logic          q_full,
  output logic               q_push,
  output gsp_pkg::gsp_sent_t q_data
);

  logic [3:0]  fld_r,    fld_nxt;
  logic [19:0] time_r,   time_nxt;
  logic [29:0] lat_r,    lat_nxt;
  logic [3:0]  latlen_r, latlen_nxt;
  logic [30:0] lon_r,    lon_nxt;
  logic [2:0]  frac_r,   frac_nxt;
  logic        seen_r,   seen_nxt;
  logic [7:0]  ns_r,     ns_nxt;
  logic [7:0]  ew_r,     ew_nxt;
  logic        fix_r,    fix_nxt;
  logic [6:0]  sat_r,    sat_nxt;
  logic [22:0] alt_r,    alt_nxt;
  logic        neg_r,    neg_nxt;
  logic [7:0]  unit_r,   unit_nxt;

  logic       beat;
  logic [7:0] c;

  assign in_if.ready = !q_full;
  assign beat        = in_if.valid && in_if.ready;
  assign c           = in_if.sentence_byte;
  assign q_push      = beat && in_if.sentence_end;

  // per-character update of the sentence state
  always_comb begin
    gsp_pkg::gsp_fix_t fx;
    gsp_pkg::gsp_int_t ic;
    fx         = '0;
    ic         = '0;
    fld_nxt    = fld_r;
    time_nxt   = time_r;
    lat_nxt    = lat_r;
    latlen_nxt = latlen_r;
    lon_nxt    = lon_r;
    frac_nxt   = frac_r;
    seen_nxt   = seen_r;
    ns_nxt     = ns_r;
    ew_nxt     = ew_r;
    fix_nxt    = fix_r;
    sat_nxt    = sat_r;
    alt_nxt    = alt_r;
    neg_nxt    = neg_r;
    unit_nxt   = unit_r;
    if (c == gsp_pkg::CH_COMMA) begin
      if (fld_r != gsp_pkg::FLD_MAX) fld_nxt = fld_r + 4'd1;
      seen_nxt = 1'b0;
      frac_nxt = '0;
    end else begin
      case (fld_r)
        gsp_pkg::FLD_TIME: begin
          ic = gsp_pkg::gsp_int_char(time_r, c, seen_r, gsp_pkg::TIME_MAX);
          time_nxt = ic.acc;
          seen_nxt = ic.seen;
        end
        gsp_pkg::FLD_LAT: begin
          if (latlen_r != gsp_pkg::FLD_MAX) latlen_nxt = latlen_r + 4'd1;
          fx = gsp_pkg::gsp_fixed_char({1'b0, lat_r}, c, seen_r, frac_r,
                                       3'(gsp_pkg::COORD_FRAC_DIGITS), gsp_pkg::LAT_MAX);
          lat_nxt  = fx.acc[29:0];
          seen_nxt = fx.seen;
          frac_nxt = fx.frac;
        end
        gsp_pkg::FLD_NS: begin
          if (!seen_r) begin
            ns_nxt   = c;
            seen_nxt = 1'b1;
          end
        end
        gsp_pkg::FLD_LON: begin
          fx = gsp_pkg::gsp_fixed_char(lon_r, c, seen_r, frac_r,
                                       3'(gsp_pkg::COORD_FRAC_DIGITS), gsp_pkg::LON_MAX);
          lon_nxt  = fx.acc;
          seen_nxt = fx.seen;
          frac_nxt = fx.frac;
        end
        gsp_pkg::FLD_EW: begin
          if (!seen_r) begin
            ew_nxt   = c;
            seen_nxt = 1'b1;
          end
        end
        gsp_pkg::FLD_FIX: begin
          if (!seen_r) begin
            fix_nxt  = c inside {gsp_pkg::CH_FIX_GPS, gsp_pkg::CH_FIX_DGPS,
                                 gsp_pkg::CH_FIX_EST};
            seen_nxt = 1'b1;
          end
        end
        gsp_pkg::FLD_SATS: begin
          ic = gsp_pkg::gsp_int_char({13'd0, sat_r}, c, seen_r, gsp_pkg::SAT_MAX);
          sat_nxt  = ic.acc[6:0];
          seen_nxt = ic.seen;
        end
        gsp_pkg::FLD_ALT: begin
          if ((c == gsp_pkg::CH_MINUS) && !seen_r && (alt_r == '0)) begin
            neg_nxt = 1'b1;
          end else begin
            fx = gsp_pkg::gsp_fixed_char({8'd0, alt_r}, c, seen_r, frac_r,
                                         3'(gsp_pkg::ALT_FRAC_DIGITS), gsp_pkg::ALT_MAX);
            alt_nxt  = fx.acc[22:0];
            seen_nxt = fx.seen;
            frac_nxt = fx.frac;
          end
        end
        gsp_pkg::FLD_UNIT: begin
          if (!seen_r) begin
            unit_nxt = c;
            seen_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // finished sentence, including its last byte
  always_comb begin
    q_data.time_acc    = time_nxt;
    q_data.lat_acc     = lat_nxt;
    q_data.lat_short   = latlen_nxt < gsp_pkg::LAT_MIN_LEN;
    q_data.lon_acc     = lon_nxt;
    q_data.ns_letter   = ns_nxt;
    q_data.ew_letter   = ew_nxt;
    q_data.fix_ok      = fix_nxt;
    q_data.sat_acc     = sat_nxt;
    q_data.alt_mag     = alt_nxt;
    q_data.alt_neg     = neg_nxt;
    q_data.unit_letter = unit_nxt;
  end

  // sentence state, cleared at reset and after every last byte
  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      fld_r    <= '0;
      time_r   <= '0;
      lat_r    <= '0;
      latlen_r <= '0;
      lon_r    <= '0;
      frac_r   <= '0;
      seen_r   <= 1'b0;
      ns_r     <= '0;
      ew_r     <= '0;
      fix_r    <= 1'b0;
      sat_r    <= '0;
      alt_r    <= '0;
      neg_r    <= 1'b0;
      unit_r   <= '0;
    end else if (beat) begin
      fld_r    <= fld_nxt;
      time_r   <= time_nxt;
      lat_r    <= lat_nxt;
      latlen_r <= latlen_nxt;
      lon_r    <= lon_nxt;
      frac_r   <= frac_nxt;
      seen_r   <= seen_nxt;
      ns_r     <= ns_nxt;
      ew_r     <= ew_nxt;
      fix_r    <= fix_nxt;
      sat_r    <= sat_nxt;
      alt_r    <= alt_nxt;
      neg_r    <= neg_nxt;
      unit_r   <= unit_nxt;
    end
  end

endmodule

`default_nettype wire

[src/gsp_queue.sv]
// gsp_queue: small register fifo of finished sentences between the byte
// parser and the result pipeline
// depends on gsp_pkg
`default_nettype none

module gsp_queue #(
  parameter int DEPTH = gsp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire gsp_pkg::gsp_sent_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output gsp_pkg::gsp_sent_t      head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gsp_pkg::gsp_sent_t mem [DEPTH];

  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_data;
  end

endmodule

`default_nettype wire

[src/gsp_back.sv]
// gsp_back: result pipeline; splits hhmmss, applies the utc offset, forms the
// status and drives the result register; holds the offset register
// depends on gsp_pkg and gsp_ifs
`default_nettype none

module gsp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  gsp_cfg_if.sink                 cfg_if,
  gsp_result_if.source            out_if,
  input  wire logic               q_valid,
  input  wire gsp_pkg::gsp_sent_t q_data,
  output logic                    q_pop
);

  // offset register and its hour / minute parts
  logic signed [11:0] offset_r;
  logic signed [5:0]  offh_r, offh_nxt;
  logic signed [7:0]  offm_r, offm_nxt;
  logic [11:0]        off_mag;
  logic [23:0]        off_prod;
  logic [4:0]         off_q;
  logic [11:0]        off_rem;

  // pipeline registers
  logic               v1_r, v2_r, v3_r;
  logic               en1, en2, en3;
  logic [13:0]        s1_q_r;
  gsp_pkg::gsp_sent_t s1_d_r;
  logic [13:0]        s2_q_r;
  logic [6:0]         s2_hh_r;
  logic [6:0]         s2_ss_r;
  gsp_pkg::gsp_sent_t s2_d_r;

  logic [40:0]        t_prod;
  logic [19:0]        ss_full;
  logic [27:0]        hh_prod;
  logic [13:0]        mm_full;
  logic signed [7:0]  h_sum;
  logic signed [8:0]  m_sum;
  logic [6:0]         hour_sat;
  logic [7:0]         min_sat;
  logic [23:0]        alt_val;

  // result register
  logic [1:0]  st_r;
  logic [6:0]  hour_r;
  logic [7:0]  min_r;
  logic [6:0]  sec_r;
  logic [29:0] lat_r;
  logic [7:0]  ns_r;
  logic [30:0] lon_r;
  logic [7:0]  ew_r;
  logic [6:0]  sat_r;
  logic [23:0] alt_r;
  logic [7:0]  unit_r;

  assign cfg_if.ready = 1'b1;

  // offset/100 and offset%100, truncated toward zero
  always_comb begin
    off_mag  = offset_r[11] ? 12'(-offset_r) : offset_r;
    off_prod = 24'(off_mag) * 24'(gsp_pkg::OFF_RECIP);
    off_q    = off_prod[gsp_pkg::OFF_SHIFT +: 5];
    off_rem  = off_mag - 12'(off_q) * 12'd100;
    offh_nxt = offset_r[11] ? -$signed({1'b0, off_q}) : $signed({1'b0, off_q});
    offm_nxt = offset_r[11] ? -$signed({1'b0, off_rem[6:0]}) : $signed({1'b0, off_rem[6:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= gsp_pkg::UTC_OFFSET_RST;
      offh_r   <= 6'sd5;
      offm_r   <= 8'sd30;
    end else begin
      if (cfg_if.valid && cfg_if.ready) offset_r <= cfg_if.utc_offset_hhmm;
      offh_r <= offh_nxt;
      offm_r <= offm_nxt;
    end
  end

  // stage enables, each stage moves when the next one has room
  assign en3   = !v3_r || out_if.ready;
  assign en2   = !v2_r || en3;
  assign en1   = !v1_r || en2;
  assign q_pop = q_valid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= q_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // stage 1: hhmm = hhmmss / 100
  assign t_prod = 41'(q_data.time_acc) * 41'(gsp_pkg::TIME_RECIP);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_q_r <= t_prod[gsp_pkg::TIME_SHIFT +: 14];
      s1_d_r <= q_data;
    end
  end

  // stage 2: seconds and hh = hhmm / 100
  assign ss_full = s1_d_r.time_acc - 20'(s1_q_r) * 20'd100;
  assign hh_prod = 28'(s1_q_r) * 28'(gsp_pkg::HUND_RECIP);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_q_r  <= s1_q_r;
      s2_hh_r <= hh_prod[gsp_pkg::HUND_SHIFT +: 7];
      s2_ss_r <= ss_full[6:0];
      s2_d_r  <= s1_d_r;
    end
  end

  // stage 3: minutes, offset, saturation, status
  always_comb begin
    mm_full = s2_q_r - 14'(s2_hh_r) * 14'd100;
    h_sum   = $signed({1'b0, s2_hh_r}) + 8'(offh_r);
    m_sum   = $signed({2'b0, mm_full[6:0]}) + 9'(offm_r);
    if (h_sum > 8'sd63)        hour_sat = 7'h3F;
    else if (h_sum < -8'sd64)  hour_sat = 7'h40;
    else                       hour_sat = h_sum[6:0];
    if (m_sum > 9'sd127)       min_sat = 8'h7F;
    else if (m_sum < -9'sd128) min_sat = 8'h80;
    else                       min_sat = m_sum[7:0];
    alt_val = s2_d_r.alt_neg ? -{1'b0, s2_d_r.alt_mag} : {1'b0, s2_d_r.alt_mag};
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      st_r   <= gsp_pkg::ST_OK;
      hour_r <= '0;
      min_r  <= '0;
      sec_r  <= '0;
      lat_r  <= '0;
      ns_r   <= '0;
      lon_r  <= '0;
      ew_r   <= '0;
      sat_r  <= '0;
      alt_r  <= '0;
      unit_r <= '0;
      if (!s2_d_r.fix_ok) begin
        st_r <= gsp_pkg::ST_NO_FIX;
      end else begin
        hour_r <= hour_sat;
        min_r  <= min_sat;
        sec_r  <= s2_ss_r;
        if (s2_d_r.lat_short) begin
          st_r <= gsp_pkg::ST_SHORT_LAT;
        end else begin
          lat_r  <= s2_d_r.lat_acc;
          ns_r   <= s2_d_r.ns_letter;
          lon_r  <= s2_d_r.lon_acc;
          ew_r   <= s2_d_r.ew_letter;
          sat_r  <= s2_d_r.sat_acc;
          alt_r  <= alt_val;
          unit_r <= s2_d_r.unit_letter;
        end
      end
    end
  end

  assign out_if.valid         = v3_r;
  assign out_if.status        = st_r;
  assign out_if.hour          = hour_r;
  assign out_if.minute        = min_r;
  assign out_if.second        = sec_r;
  assign out_if.latitude      = lat_r;
  assign out_if.north_south   = ns_r;
  assign out_if.longitude     = lon_r;
  assign out_if.east_west     = ew_r;
  assign out_if.satellites    = sat_r;
  assign out_if.altitude      = alt_r;
  assign out_if.altitude_unit = unit_r;

endmodule

`default_nettype wire

[src/gsp_checker.sv]
// gsp_checker: port-level assertions for gga_sentence_parser, bound to it
// depends on gsp_pkg
`default_nettype none

module gsp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_end,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [6:0]  hour,
  input wire logic [7:0]  minute,
  input wire logic [6:0]  second,
  input wire logic [29:0] latitude,
  input wire logic [7:0]  north_south,
  input wire logic [30:0] longitude,
  input wire logic [7:0]  east_west,
  input wire logic [6:0]  satellites,
  input wire logic [23:0] altitude,
  input wire logic [7:0]  altitude_unit
);

  // sentences ended but not yet answered
  logic [3:0] pend_r;
  logic       end_beat, res_beat;

  assign end_beat = in_valid && in_ready && in_end;
  assign res_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(end_beat) - 4'(res_beat);
    end
  end

  // a result always answers an earlier last byte
  a_result_has_sentence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 4'd0))
    else $error("result without a pending sentence");

  // reset empties the result register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(hour)
      && $stable(latitude) && $stable(altitude))
    else $error("stalled result changed");

  // no fix reports zero time, coordinates, satellites and altitude
  a_no_fix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == gsp_pkg::ST_NO_FIX) |-> (hour == '0) && (minute == '0)
      && (second == '0) && (latitude == '0) && (longitude == '0)
      && (satellites == '0) && (altitude == '0))
    else $error("no-fix result carries data");

  // short latitude keeps only the time
  a_short_lat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == gsp_pkg::ST_SHORT_LAT) |-> (latitude == '0)
      && (north_south == '0) && (longitude == '0) && (east_west == '0)
      && (satellites == '0) && (altitude == '0) && (altitude_unit == '0))
    else $error("short-latitude result carries position");

endmodule

bind gga_sentence_parser gsp_checker u_gsp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_end        (in_if.sentence_end),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .status        (out_if.status),
  .hour          (out_if.hour),
  .minute        (out_if.minute),
  .second        (out_if.second),
  .latitude      (out_if.latitude),
  .north_south   (out_if.north_south),
  .longitude     (out_if.longitude),
  .east_west     (out_if.east_west),
  .satellites    (out_if.satellites),
  .altitude      (out_if.altitude),
  .altitude_unit (out_if.altitude_unit)
);

`default_nettype wire

[test/gga_fix_model_pkg.sv]
`timescale 1ns / 100ps
// gga_fix_model_pkg: expected-result type and scoreboard class for the gga
// sentence parser testbench; depends on gsp_pkg from src

package gga_fix_model_pkg;
  import gsp_pkg::*;

  // one parsed result, fields in the order of the result channel
  typedef struct packed {
    logic [1:0]         status;
    logic signed [6:0]  hour;
    logic signed [7:0]  minute;
    logic [6:0]         second;
    logic [29:0]        latitude;
    logic [7:0]         north_south;
    logic [30:0]        longitude;
    logic [7:0]         east_west;
    logic [6:0]         satellites;
    logic signed [23:0] altitude;
    logic [7:0]         altitude_unit;
  } gga_fix_t;

  // tracks the sentence being parsed and holds the results still owed
  class gga_fix_model;
    logic signed [11:0] offset_hhmm;
    logic [3:0]         field_no;
    logic [19:0]        time_acc;
    logic [29:0]        lat_acc;
    logic [3:0]         lat_len;
    logic [30:0]        lon_acc;
    logic [2:0]         frac_cnt;
    logic               seen;
    logic [7:0]         ns_chr;
    logic [7:0]         ew_chr;
    logic               fix_ok;
    logic [6:0]         sat_acc;
    logic [23:0]        alt_mag;
    logic               alt_neg;
    logic [7:0]         unit_chr;
    gga_fix_t           pending_fixes[$];
    int unsigned        errors;
    int unsigned        n_checked;
    int unsigned        n_status[3];

    function new();
      offset_hhmm = UTC_OFFSET_RST;
      errors      = 0;
      n_checked   = 0;
      n_status    = '{0, 0, 0};
      clear_sentence();
    endfunction

    function void set_offset(logic signed [11:0] v);
      offset_hhmm = v;
    endfunction

    function void clear_sentence();
      field_no = '0; time_acc = '0; lat_acc = '0; lat_len = '0; lon_acc = '0;
      frac_cnt = '0; seen = 1'b0; ns_chr = '0; ew_chr = '0; fix_ok = 1'b0;
      sat_acc = '0; alt_mag = '0; alt_neg = 1'b0; unit_chr = '0;
    endfunction

    function longint unsigned ten_pow(int n);
      longint unsigned p;
      p = 1;
      repeat (n) p = p * 10;
      return p;
    endfunction

    function longint unsigned cap_at(longint unsigned v, longint unsigned cap);
      return (v > cap) ? cap : v;
    endfunction

    // digit, point or other character of a fixed-point field
    function longint unsigned fixed_digit(longint unsigned acc, logic [7:0] c, int scale,
                                          longint unsigned cap);
      longint unsigned d;
      if (c == CH_POINT) begin
        seen = 1'b1;
        return acc;
      end
      if (c < CH_ZERO || c > CH_NINE) return acc;
      d = longint'(c) - longint'(CH_ZERO);
      if (!seen) return cap_at(acc * 10 + d * ten_pow(scale), cap);
      if (frac_cnt < scale) begin
        frac_cnt++;
        return cap_at(acc + d * ten_pow(scale - frac_cnt), cap);
      end
      return acc;
    endfunction

    // integer field, closed by its first non-digit
    function longint unsigned digit_run(longint unsigned acc, logic [7:0] c,
                                        longint unsigned cap);
      if (seen) return acc;
      if (c < CH_ZERO || c > CH_NINE) begin
        seen = 1'b1;
        return acc;
      end
      return cap_at(acc * 10 + (longint'(c) - longint'(CH_ZERO)), cap);
    endfunction

    // one accepted input beat; the last byte of a sentence owes a result
    function void take_byte(logic [7:0] c, logic is_last);
      gga_fix_t r;
      int       tm;
      int       off;
      int       h;
      int       m;
      int       a;
      if (c == CH_COMMA) begin
        if (field_no < FLD_MAX) field_no++;
        seen     = 1'b0;
        frac_cnt = '0;
      end else begin
        case (field_no)
          FLD_TIME: time_acc = 20'(digit_run(time_acc, c, TIME_MAX));
          FLD_LAT: begin
            if (lat_len < 4'd15) lat_len++;
            lat_acc = 30'(fixed_digit(lat_acc, c, COORD_FRAC_DIGITS, LAT_MAX));
          end
          FLD_NS: if (!seen) begin
            ns_chr = c;
            seen   = 1'b1;
          end
          FLD_LON: lon_acc = 31'(fixed_digit(lon_acc, c, COORD_FRAC_DIGITS, LON_MAX));
          FLD_EW: if (!seen) begin
            ew_chr = c;
            seen   = 1'b1;
          end
          FLD_FIX: if (!seen) begin
            fix_ok = (c == CH_FIX_GPS) || (c == CH_FIX_DGPS) || (c == CH_FIX_EST);
            seen   = 1'b1;
          end
          FLD_SATS: sat_acc = 7'(digit_run(sat_acc, c, SAT_MAX));
          FLD_ALT: begin
            if (c == CH_MINUS && !seen && alt_mag == 0) alt_neg = 1'b1;
            else alt_mag = 24'(fixed_digit(alt_mag, c, ALT_FRAC_DIGITS, ALT_MAX));
          end
          FLD_UNIT: if (!seen) begin
            unit_chr = c;
            seen     = 1'b1;
          end
          default: ;
        endcase
      end
      if (!is_last) return;

      // build the result; no fix wins over a short latitude
      r = '0;
      if (!fix_ok) begin
        r.status = ST_NO_FIX;
      end else begin
        tm  = int'(time_acc);
        off = offset_hhmm;
        h   = tm / 10000 + off / 100;
        m   = (tm / 100) % 100 + off % 100;
        h   = (h < -64) ? -64 : ((h > 63) ? 63 : h);
        m   = (m < -128) ? -128 : ((m > 127) ? 127 : m);
        r.hour   = 7'(h);
        r.minute = 8'(m);
        r.second = 7'(tm % 100);
        if (lat_len < LAT_MIN_LEN) begin
          r.status = ST_SHORT_LAT;
        end else begin
          a = alt_neg ? -int'(alt_mag) : int'(alt_mag);
          r.status        = ST_OK;
          r.latitude      = lat_acc;
          r.north_south   = ns_chr;
          r.longitude     = lon_acc;
          r.east_west     = ew_chr;
          r.satellites    = sat_acc;
          r.altitude      = 24'(a);
          r.altitude_unit = unit_chr;
        end
      end
      n_status[r.status]++;
      pending_fixes.push_back(r);
      clear_sentence();
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want == got) return;
      errors++;
      if (errors <= 10)
        $display("result %0d %s: expected %0d, got %0d", n_checked, name, want, got);
    endfunction

    // one accepted result beat against the oldest result owed
    function void match_fix(gga_fix_t got);
      gga_fix_t want;
      if (pending_fixes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with status %0d but no sentence pending", got.status);
        return;
      end
      want = pending_fixes.pop_front();
      n_checked++;
      check_field("status", want.status, got.status);
      check_field("hour", want.hour, got.hour);
      check_field("minute", want.minute, got.minute);
      check_field("second", want.second, got.second);
      check_field("latitude", want.latitude, got.latitude);
      check_field("north_south", want.north_south, got.north_south);
      check_field("longitude", want.longitude, got.longitude);
      check_field("east_west", want.east_west, got.east_west);
      check_field("satellites", want.satellites, got.satellites);
      check_field("altitude", want.altitude, got.altitude);
      check_field("altitude_unit", want.altitude_unit, got.altitude_unit);
    endfunction

    function void close_out();
      if (pending_fixes.size() != 0) begin
        errors += pending_fixes.size();
        $display("%0d sentences never produced a result", pending_fixes.size());
      end
    endfunction
  endclass

endpackage

[test/tb.sv]
`timescale 1ns / 100ps
// tb: feeds gga_sentence_parser directed and random gga sentences through
// three idle mixes and six offset settings, checking every result beat;
// depends on gsp_pkg, gsp_ifs, gga_fix_model_pkg and the rtl under src

module tb;
  import gsp_pkg::*;
  import gga_fix_model_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SEGMENTS      = 6;
  localparam int SEG_BYTES     = 250;
  localparam int SEG_SENTENCES = 4;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;

  gsp_byte_if   in_if ();
  gsp_result_if out_if ();
  gsp_cfg_if    cfg_if ();

  gga_sentence_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  gga_fix_model board = new();

  logic [7:0]  line_bytes[$];
  int          send_gap_pct = 0;
  int          recv_gap_pct = 0;
  int unsigned n_bytes = 0;
  int unsigned quiet_cycles = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result beats are checked, then ready is redrawn
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      board.match_fix({out_if.status, out_if.hour, out_if.minute, out_if.second,
                       out_if.latitude, out_if.north_south, out_if.longitude,
                       out_if.east_west, out_if.satellites, out_if.altitude,
                       out_if.altitude_unit});
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_gap_pct);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one sentence byte, after a random idle stretch
  task automatic push_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.sentence_byte <= b;
    in_if.sentence_end  <= e;
    do @(posedge clk); while (!in_if.ready);
    n_bytes++;
    board.take_byte(b, e);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) push_byte(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  task automatic write_offset(input logic signed [11:0] v);
    cfg_if.valid           <= 1'b1;
    cfg_if.utc_offset_hhmm <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    board.set_offset(v);
  endtask

  // wait for every owed result, then let the pipeline empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (board.pending_fixes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sentence text helpers
  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, 8'h7E));
    return (c == CH_COMMA) ? CH_MINUS : c;
  endfunction

  task automatic add_text(input string s);
    foreach (s[i]) line_bytes.push_back(s[i]);
  endtask

  task automatic add_digits(input int n, input bit nines);
    repeat (n) line_bytes.push_back(nines ? CH_NINE : 8'(CH_ZERO + $urandom_range(9)));
  endtask

  task automatic add_two(input int v);
    line_bytes.push_back(8'(CH_ZERO + v / 10));
    line_bytes.push_back(8'(CH_ZERO + v % 10));
  endtask

  // digits, optional point and fraction, now and then a stray character
  task automatic add_number(input int whole, input int frac, input bit nines, input bit point);
    add_digits(whole, nines);
    if (point) begin
      line_bytes.push_back(CH_POINT);
      add_digits(frac, nines);
    end
    if ($urandom_range(15) == 0) begin
      line_bytes.push_back(stray_char());
      add_digits($urandom_range(2), 1'b0);
    end
  endtask

  // letter field: usually one of the choices, sometimes empty or odd
  task automatic add_letter(input string choices);
    case ($urandom_range(9))
      0: ;
      1: line_bytes.push_back(stray_char());
      default: line_bytes.push_back(choices[$urandom_range(choices.len() - 1)]);
    endcase
    if ($urandom_range(7) == 0) line_bytes.push_back(stray_char());
  endtask

  // a gga sentence with random content, optionally cut short
  task automatic build_gga(input bit truncate);
    int keep;
    bit nines;
    line_bytes.delete();
    add_text("$GPGGA,");
    // time of day
    case ($urandom_range(7))
      0: ;
      1: add_number($urandom_range(7, 9), 0, 1'b1, 1'b0);
      2: add_number($urandom_range(1, 6), $urandom_range(3), $urandom_range(1), 1'b1);
      default: begin
        add_two($urandom_range(23));
        add_two($urandom_range(59));
        add_two($urandom_range(59));
        add_number(0, $urandom_range(3), 1'b0, $urandom_range(3) != 0);
      end
    endcase
    // latitude and hemisphere
    add_text(",");
    nines = ($urandom_range(7) == 0);
    if ($urandom_range(4) != 0) add_number(4, $urandom_range(7), nines, 1'b1);
    else add_number($urandom_range(11), $urandom_range(3), nines, $urandom_range(1));
    add_text(",");
    add_letter("NS");
    // longitude and hemisphere
    add_text(",");
    nines = ($urandom_range(7) == 0);
    if ($urandom_range(4) != 0) add_number(5, $urandom_range(7), nines, 1'b1);
    else add_number($urandom_range(12), $urandom_range(3), nines, $urandom_range(1));
    add_text(",");
    add_letter("EW");
    // fix quality
    add_text(",");
    case ($urandom_range(11))
      0: ;
      1: line_bytes.push_back(CH_ZERO);
      2: line_bytes.push_back(stray_char());
      3: line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
      4, 5, 6: line_bytes.push_back(CH_FIX_GPS);
      7, 8: line_bytes.push_back(CH_FIX_DGPS);
      default: line_bytes.push_back(CH_FIX_EST);
    endcase
    // satellites, then hdop which is skipped
    add_text(",");
    if ($urandom_range(7) == 0) add_number($urandom_range(3, 5), 0, $urandom_range(1), 1'b0);
    else add_number($urandom_range(2), 0, 1'b0, 1'b0);
    add_text(",");
    add_number($urandom_range(2), $urandom_range(2), 1'b0, 1'b1);
    // altitude and unit
    add_text(",");
    if ($urandom_range(2) == 0) line_bytes.push_back(CH_MINUS);
    nines = ($urandom_range(5) == 0);
    if ($urandom_range(7) == 0) add_number($urandom_range(6, 9), $urandom_range(4), nines, 1'b1);
    else add_number($urandom_range(5), $urandom_range(4), nines, $urandom_range(1));
    add_text(",");
    add_letter("MF");
    add_text(",-34.0,M,,*");
    add_digits(2, 1'b0);
    if (truncate) begin
      keep = $urandom_range(1, line_bytes.size());
      while (line_bytes.size() > keep) void'(line_bytes.pop_back());
    end
  endtask

  // random bytes with a random share of commas
  task automatic build_noise();
    int n;
    int comma_pct;
    line_bytes.delete();
    n         = $urandom_range(1, 30);
    comma_pct = $urandom_range(60);
    repeat (n)
      line_bytes.push_back(($urandom_range(99) < comma_pct) ? CH_COMMA
                                                            : 8'($urandom_range(255)));
  endtask

  initial begin : stimulus
    int                 seg;
    int                 seg_bytes;
    int                 seg_lines;
    int                 mode;
    logic signed [11:0] new_off;
    logic [7:0]         fix_codes[3];

    rst_n                  <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.sentence_byte    <= '0;
    in_if.sentence_end     <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.utc_offset_hhmm <= '0;
    fix_codes = '{CH_FIX_GPS, CH_FIX_DGPS, CH_FIX_EST};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      // idle mix: sender light then heavy, then none
      case (seg / 2)
        0: begin send_gap_pct = 22; recv_gap_pct = 48; end
        1: begin send_gap_pct = 48; recv_gap_pct = 22; end
        default: begin send_gap_pct = 0; recv_gap_pct = 0; end
      endcase

      if (seg == 0) begin
        // one-byte sentences at both byte extremes: no fix
        line_bytes = '{8'h00};
        send_line();
        line_bytes = '{8'hFF};
        send_line();
        // each valid fix code with an empty latitude: short latitude
        foreach (fix_codes[i]) begin
          line_bytes.delete();
          add_text(",,,,,,");
          line_bytes.push_back(fix_codes[i]);
          send_line();
        end
      end else begin
        case (seg)
          1: new_off = -12'sd1200;
          2: new_off = 12'sd1400;
          3: new_off = 12'(int'($urandom_range(2600)) - 1200);
          4: new_off = 12'h800;
          default: new_off = 12'h7FF;
        endcase
        settle();
        write_offset(new_off);
      end

      seg_bytes = 0;
      seg_lines = 0;
      while (seg_bytes < SEG_BYTES || seg_lines < SEG_SENTENCES) begin
        mode = $urandom_range(99);
        if (mode < 72) build_gga(1'b0);
        else if (mode < 86) build_gga(1'b1);
        else build_noise();
        seg_bytes += line_bytes.size();
        seg_lines++;
        send_line();
      end
    end

    settle();
    board.close_out();
    $display("covered %0d bytes in %0d sentences, %0d offset settings, three idle mixes",
             n_bytes, board.n_checked, SEGMENTS);
    $display("statuses: %0d parsed, %0d without fix, %0d short latitude; %0d errors",
             board.n_status[ST_OK], board.n_status[ST_NO_FIX],
             board.n_status[ST_SHORT_LAT], board.errors);
    if (board.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
